// File: design/utf8_sanitize_line_split_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8_sanitize_line_split_unit assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZE_LINE_SPLIT_UNIT_MACROS_SVH
`define UTF8_SANITIZE_LINE_SPLIT_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define U8SLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define U8SLS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: design/u8sls_pkg.sv
// ----------------------------------------------------------------------------
// u8sls_pkg
// Constants, run descriptor type and byte helpers for the utf-8 sanitizer.
// ----------------------------------------------------------------------------
package u8sls_pkg;

  localparam logic [7:0] LF          = 8'h0a;
  localparam logic [7:0] CR          = 8'h0d;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hc2;
  localparam logic [7:0] LEAD3_MIN   = 8'he0;
  localparam logic [7:0] LEAD4_MIN   = 8'hf0;
  localparam logic [7:0] LEAD_LIMIT  = 8'hf8;
  localparam logic [7:0] LEAD_E0     = 8'he0;
  localparam logic [7:0] LEAD_ED     = 8'hed;
  localparam logic [7:0] LEAD_F0     = 8'hf0;
  localparam logic [7:0] LEAD_F4     = 8'hf4;
  localparam logic [7:0] SURR_MIN    = 8'ha0;
  localparam logic [7:0] F4_MAX      = 8'h8f;
  localparam logic [7:0] LATIN_HI    = 8'hc0;
  localparam logic [7:0] LATIN_LO    = 8'h80;

  localparam int MAX_BYTES = 4;

  typedef logic [7:0] u8_t;

  // one accepted byte's worth of output work
  typedef struct packed {
    logic                     cr;      // emit a held carriage return first
    logic                     line;    // emit a line end item
    logic [2:0]               nbytes;  // bytes to emit, 0 to 4
    logic                     latin;   // bytes are re-encoded as latin-1
    logic [MAX_BYTES-1:0][7:0] bytes;
  } run_t;

  typedef struct packed {
    logic       cr_pending;
    logic [1:0] bytes_held;
  } front_stat_t;

  function automatic logic is_cont(input u8_t b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic u8_t latin_hi(input u8_t b);
    return LATIN_HI | {6'd0, b[7:6]};
  endfunction

  function automatic u8_t latin_lo(input u8_t b);
    return LATIN_LO | {2'd0, b[5:0]};
  endfunction

endpackage

// File: design/u8sls_in_if.sv
// ----------------------------------------------------------------------------
// u8sls_in_if
// Raw byte channel into the sanitizer.
// ----------------------------------------------------------------------------
interface u8sls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: design/u8sls_out_if.sv
// ----------------------------------------------------------------------------
// u8sls_out_if
// Sanitized result channel out of the sanitizer.
// ----------------------------------------------------------------------------
interface u8sls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output line_end, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input line_end, input last_of_run,
                output ready);
endinterface

// File: design/u8sls_front.sv
// ----------------------------------------------------------------------------
// u8sls_front
// Accepts raw bytes, tracks the pending sequence and classifies each byte
// into a run descriptor for the back end.
// ----------------------------------------------------------------------------
module u8sls_front (
  input  logic                  clk,
  input  logic                  rst,
  u8sls_in_if.sink              in_ch,
  input  logic                  q_full,
  output logic                  push,
  output u8sls_pkg::run_t       run,
  output u8sls_pkg::front_stat_t stat
);

  u8sls_pkg::u8_t held_lead, held_second, held_third;
  u8sls_pkg::u8_t held_lead_next, held_second_next, held_third_next;
  logic [1:0]     bytes_held, bytes_held_next;
  logic [1:0]     bytes_expected, bytes_expected_next;
  logic           cr_pending, cr_pending_next;

  u8sls_pkg::u8_t b;
  logic           accept;
  logic           second_bad;

  assign b           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    second_bad = !u8sls_pkg::is_cont(b);
    if (bytes_expected == 2'd2) begin
      if ((held_lead == u8sls_pkg::LEAD_E0 && !b[5]) ||
          (held_lead == u8sls_pkg::LEAD_ED && b >= u8sls_pkg::SURR_MIN))
        second_bad = 1'b1;
    end else if (bytes_expected == 2'd3) begin
      if ((held_lead == u8sls_pkg::LEAD_F0 && b[5:4] == 2'b00) ||
          held_lead > u8sls_pkg::LEAD_F4 ||
          (held_lead == u8sls_pkg::LEAD_F4 && b > u8sls_pkg::F4_MAX))
        second_bad = 1'b1;
    end
  end

  always_comb begin
    held_lead_next      = held_lead;
    held_second_next    = held_second;
    held_third_next     = held_third;
    bytes_held_next     = bytes_held;
    bytes_expected_next = bytes_expected;
    cr_pending_next     = 1'b0;

    run.cr     = 1'b0;
    run.line   = 1'b0;
    run.nbytes = 3'd0;
    run.latin  = 1'b0;
    // the new byte lands right after the held ones
    run.bytes[0] = (bytes_held == 2'd0) ? b : held_lead;
    run.bytes[1] = (bytes_held == 2'd1) ? b : held_second;
    run.bytes[2] = (bytes_held == 2'd2) ? b : held_third;
    run.bytes[3] = b;

    if (cr_pending && b == u8sls_pkg::LF) begin
      run.line = 1'b1;
    end else begin
      run.cr = cr_pending;
      unique case (bytes_held)
        2'd0: begin
          if (b < u8sls_pkg::ASCII_LIMIT) begin
            if (b == u8sls_pkg::LF) run.line = 1'b1;
            else if (b == u8sls_pkg::CR) cr_pending_next = 1'b1;
            else run.nbytes = 3'd1;
          end else if (b < u8sls_pkg::LEAD2_MIN || b >= u8sls_pkg::LEAD_LIMIT) begin
            run.nbytes = 3'd1;
            run.latin  = 1'b1;
          end else begin
            held_lead_next      = b;
            bytes_held_next     = 2'd1;
            bytes_expected_next = (b < u8sls_pkg::LEAD3_MIN) ? 2'd1 :
                                  (b < u8sls_pkg::LEAD4_MIN) ? 2'd2 : 2'd3;
          end
        end
        2'd1: begin
          if (second_bad || bytes_expected <= 2'd1) begin
            run.nbytes          = 3'd2;
            run.latin           = second_bad;
            bytes_held_next     = 2'd0;
            bytes_expected_next = 2'd0;
          end else begin
            held_second_next = b;
            bytes_held_next  = 2'd2;
          end
        end
        2'd2: begin
          if (!u8sls_pkg::is_cont(b) || bytes_expected <= 2'd2) begin
            run.nbytes          = 3'd3;
            run.latin           = !u8sls_pkg::is_cont(b);
            bytes_held_next     = 2'd0;
            bytes_expected_next = 2'd0;
          end else begin
            held_third_next = b;
            bytes_held_next = 2'd3;
          end
        end
        2'd3: begin
          run.nbytes          = 3'd4;
          run.latin           = !u8sls_pkg::is_cont(b);
          bytes_held_next     = 2'd0;
          bytes_expected_next = 2'd0;
        end
      endcase
    end
  end

  assign push = accept && (run.cr || run.line || run.nbytes != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held     <= 2'd0;
      bytes_expected <= 2'd0;
      cr_pending     <= 1'b0;
    end else if (accept) begin
      bytes_held     <= bytes_held_next;
      bytes_expected <= bytes_expected_next;
      cr_pending     <= cr_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead   <= '0;
      held_second <= '0;
      held_third  <= '0;
    end else if (accept) begin
      held_lead   <= held_lead_next;
      held_second <= held_second_next;
      held_third  <= held_third_next;
    end
  end

  assign stat.cr_pending = cr_pending;
  assign stat.bytes_held = bytes_held;

endmodule

// File: design/u8sls_queue.sv
// ----------------------------------------------------------------------------
// u8sls_queue
// Small run descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module u8sls_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8sls_pkg::run_t push_run,
  input  logic            pop,
  output u8sls_pkg::run_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8sls_pkg::run_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: design/u8sls_back.sv
// ----------------------------------------------------------------------------
// u8sls_back
// Expands the head run descriptor into result items, one per cycle while
// out_ch is ready, through an output register.
// ----------------------------------------------------------------------------
module u8sls_back (
  input  logic            clk,
  input  logic            rst,
  input  u8sls_pkg::run_t head,
  input  logic            head_valid,
  output logic            pop,
  u8sls_out_if.source     out_ch
);

  logic           out_valid;
  u8sls_pkg::u8_t out_byte;
  logic           line_end, last_of_run;

  logic           cr_done, cr_done_next;
  logic [1:0]     idx, idx_next;
  logic           half, half_next;

  u8sls_pkg::u8_t cur, item_byte;
  logic           item_line, item_last, split;
  logic           load;

  assign load = head_valid && (!out_valid || out_ch.ready);
  assign pop  = load && item_last;

  always_comb begin
    cur          = head.bytes[idx];
    split        = head.latin && cur[7];
    item_byte    = cur;
    item_line    = 1'b0;
    item_last    = 1'b0;
    cr_done_next = cr_done;
    idx_next     = idx;
    half_next    = half;

    if (head.cr && !cr_done) begin
      item_byte    = u8sls_pkg::CR;
      item_last    = !head.line && head.nbytes == 3'd0;
      cr_done_next = 1'b1;
    end else if (head.line) begin
      item_byte = '0;
      item_line = 1'b1;
      item_last = 1'b1;
    end else if (split && !half) begin
      item_byte = u8sls_pkg::latin_hi(cur);
      half_next = 1'b1;
    end else begin
      item_byte = split ? u8sls_pkg::latin_lo(cur) : cur;
      item_last = {1'b0, idx} == head.nbytes - 3'd1;
      idx_next  = idx + 2'd1;
      half_next = 1'b0;
    end

    // next run starts clean
    if (item_last) begin
      cr_done_next = 1'b0;
      idx_next     = 2'd0;
      half_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cr_done   <= 1'b0;
      idx       <= 2'd0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cr_done   <= cr_done_next;
        idx       <= idx_next;
        half      <= half_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= item_byte;
      line_end    <= item_line;
      last_of_run <= item_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.line_end    = line_end;
  assign out_ch.last_of_run = last_of_run;

endmodule

// File: design/utf8_sanitize_line_split_unit.sv
// ----------------------------------------------------------------------------
// utf8_sanitize_line_split_unit
// Byte-serial utf-8 sanitizer with latin-1 fallback and line splitting.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  in_ch     sink    in_byte[7:0]
//  out_ch    source  out_byte[7:0], line_end, last_of_run
//
//  in_ch takes one byte per cycle while the run queue (QUEUE_DEPTH) has room.
//  out_ch gives one item per cycle from the back end output register while
//  out_ch.ready holds; a byte causes 0 to 8 items, and its run passes through
//  the queue and the output register before its first item.
//  rst is synchronous and clears the sequence state, queue and output valid.
//  a stalled out_ch fills the queue, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "utf8_sanitize_line_split_unit_macros.svh"

module utf8_sanitize_line_split_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic         clk,
  input logic         rst,
  u8sls_in_if.sink    in_ch,
  u8sls_out_if.source out_ch
);

  logic                   q_push, q_pop, q_full, q_empty;
  u8sls_pkg::run_t        push_run, head;
  u8sls_pkg::front_stat_t stat;

  u8sls_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push),
    .run    (push_run),
    .stat   (stat)
  );

  u8sls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_run (push_run),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  u8sls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  `U8SLS_ASSERT(a_push_room, q_push |-> !q_full, "run pushed into a full queue")
  `U8SLS_NEVER(a_pop_empty, q_pop && q_empty, "run popped from an empty queue")
  `U8SLS_ASSERT(a_cr_idle, stat.cr_pending |-> (stat.bytes_held == 2'd0), "cr pending mid sequence")
  `U8SLS_ASSERT(a_line_last, (out_ch.valid && out_ch.line_end) |-> out_ch.last_of_run, "line end not last")

endmodule

// File: sim/u8sls_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u8sls_stream_checker
// Watches both channels of the utf-8 sanitizer, predicts the items each
// accepted byte causes and compares every delivered item in order.
// ----------------------------------------------------------------------------
module u8sls_stream_checker
  import u8sls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  u8sls_in_if   in_ch,
  u8sls_out_if  out_ch,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       last;
  } result_t;

  localparam int MAX_RUN = 8;
  localparam int MAX_SHOWN = 40;

  result_t    expected_q [$];
  result_t    run_buf [MAX_RUN];
  int         run_n;

  // decoder state mirrored from the byte stream
  logic [7:0] lead_byte;
  logic [7:0] mid_byte;
  logic [7:0] tail_byte;
  logic [1:0] held_cnt;
  logic [1:0] trail_need;
  logic       cr_wait;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic void put_result(input logic [7:0] data, input logic eol);
    if (run_n < MAX_RUN) begin
      run_buf[run_n] = '{data: data, eol: eol, last: 1'b0};
      run_n++;
    end
  endfunction

  // byte taken as latin-1 and written as utf-8
  function automatic void put_latin1(input logic [7:0] b);
    if (b < ASCII_LIMIT) begin
      put_result(b, 1'b0);
    end else begin
      put_result({6'b110000, b[7:6]}, 1'b0);
      put_result({2'b10, b[5:0]}, 1'b0);
    end
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    logic    bad;
    result_t r;
    run_n = 0;
    bad = 1'b0;
    if (cr_wait && b == LF) begin
      cr_wait = 1'b0;
      put_result(8'h00, 1'b1);
    end else begin
      // a held cr that is not part of cr lf comes out as a plain byte
      if (cr_wait) begin
        cr_wait = 1'b0;
        put_result(CR, 1'b0);
      end
      case (held_cnt)
        2'd0: begin
          if (b < ASCII_LIMIT) begin
            if (b == LF) put_result(8'h00, 1'b1);
            else if (b == CR) cr_wait = 1'b1;
            else put_result(b, 1'b0);
          end else if (b < LEAD2_MIN || b >= LEAD_LIMIT) begin
            put_latin1(b);
          end else begin
            lead_byte = b;
            held_cnt = 2'd1;
            trail_need = (b < LEAD3_MIN) ? 2'd1 : (b < LEAD4_MIN) ? 2'd2 : 2'd3;
          end
        end
        2'd1: begin
          bad = !is_trail(b);
          if (trail_need == 2'd2) begin
            bad |= (lead_byte == LEAD_E0 && !b[5]) || (lead_byte == LEAD_ED && b >= SURR_MIN);
          end else if (trail_need == 2'd3) begin
            bad |= (lead_byte == LEAD_F0 && b[5:4] == 2'b00) || lead_byte > LEAD_F4 ||
                   (lead_byte == LEAD_F4 && b > F4_MAX);
          end
          if (bad) begin
            put_latin1(lead_byte);
            put_latin1(b);
            held_cnt = 2'd0;
          end else if (trail_need == 2'd1) begin
            put_result(lead_byte, 1'b0);
            put_result(b, 1'b0);
            held_cnt = 2'd0;
          end else begin
            mid_byte = b;
            held_cnt = 2'd2;
          end
        end
        2'd2: begin
          if (!is_trail(b)) begin
            put_latin1(lead_byte);
            put_latin1(mid_byte);
            put_latin1(b);
            held_cnt = 2'd0;
          end else if (trail_need == 2'd2) begin
            put_result(lead_byte, 1'b0);
            put_result(mid_byte, 1'b0);
            put_result(b, 1'b0);
            held_cnt = 2'd0;
          end else begin
            tail_byte = b;
            held_cnt = 2'd3;
          end
        end
        default: begin
          if (!is_trail(b)) begin
            put_latin1(lead_byte);
            put_latin1(mid_byte);
            put_latin1(tail_byte);
            put_latin1(b);
          end else begin
            put_result(lead_byte, 1'b0);
            put_result(mid_byte, 1'b0);
            put_result(tail_byte, 1'b0);
            put_result(b, 1'b0);
          end
          held_cnt = 2'd0;
        end
      endcase
    end
    for (int i = 0; i < run_n; i++) begin
      r = run_buf[i];
      r.last = (i == run_n - 1);
      expected_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_q.delete();
      lead_byte = 8'h00;
      mid_byte = 8'h00;
      tail_byte = 8'h00;
      held_cnt = 2'd0;
      trail_need = 2'd0;
      cr_wait = 1'b0;
      errors = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("item with nothing expected: byte %02h eol %0b last %0b",
                                    out_ch.out_byte, out_ch.line_end, out_ch.last_of_run));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.line_end !== want.eol)
            report_mismatch($sformatf("line_end %0b, expected %0b", out_ch.line_end, want.eol));
          if (!want.eol && out_ch.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch.out_byte, want.data));
          if (out_ch.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      out_ch.last_of_run, want.last));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raw bytes into the utf-8 sanitizer: a short list of corner cases,
// then random mostly well-formed text with broken sequences and noise, under
// random idling on both sides and long output stalls. The stream checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sls_pkg::*;

  localparam int PHASE_ITEMS = 88;
  localparam int LONG_HOLD   = 240;
  localparam int DRAIN_WAIT  = 20;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   sent;
  bit   tx_calm;
  bit   rx_calm;
  int   hold_asked;
  int   hold_done;

  u8sls_in_if  in_ch();
  u8sls_out_if out_ch();

  // corner cases: cr cr lf, lone trail byte, top lead, overlong and surrogate
  // seconds, out of range four-byte leads, lf and cr as failing bytes,
  // largest code point, then cr followed by an ordinary byte
  logic [7:0] corner_bytes [$] = {
    8'h00, CR, CR, LF, 8'h80, 8'hff,
    8'he0, 8'h9f, 8'hed, 8'ha0, 8'hf0, 8'h8f, 8'hf4, 8'h90, 8'hf6, 8'hbf,
    8'he1, 8'h80, LF, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
    8'hf1, 8'h80, 8'h80, CR, 8'h41, CR, 8'h41
  };

  utf8_sanitize_line_split_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  u8sls_stream_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // well-formed sequence of len bytes, lead in s[0]
  function automatic logic [3:0][7:0] utf8_seq(input int len);
    logic [3:0][7:0] s;
    for (int i = 1; i < 4; i++) s[i] = {2'b10, 6'($urandom_range(0, 63))};
    s[0] = 8'h00;
    case (len)
      2: s[0] = 8'($urandom_range(8'hc2, 8'hdf));
      3: begin
        s[0] = 8'($urandom_range(8'he0, 8'hef));
        if (s[0] == LEAD_E0) s[1] = 8'($urandom_range(8'ha0, 8'hbf));
        else if (s[0] == LEAD_ED) s[1] = 8'($urandom_range(8'h80, 8'h9f));
      end
      default: begin
        s[0] = 8'($urandom_range(8'hf0, 8'hf4));
        if (s[0] == LEAD_F0) s[1] = 8'($urandom_range(8'h90, 8'hbf));
        else if (s[0] == LEAD_F4) s[1] = 8'($urandom_range(8'h80, 8'h8f));
      end
    endcase
    return s;
  endfunction

  task automatic send_random_text();
    int              kind;
    int              len;
    int              cut;
    int              pick;
    logic [7:0]      b;
    logic [3:0][7:0] s;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      pick = $urandom_range(0, 7);
      b = (pick == 0) ? LF : (pick == 1) ? CR : 8'($urandom_range(0, 127));
      send_byte(b);
    end else if (kind < 82) begin
      len = 2 + (kind - 40) / 14;
      s = utf8_seq(len);
      for (int i = 0; i < len; i++) send_byte(s[i]);
    end else if (kind < 92) begin
      // valid prefix cut short by an arbitrary byte, often a line break
      len = $urandom_range(2, 4);
      cut = $urandom_range(1, len - 1);
      s = utf8_seq(len);
      for (int i = 0; i < cut; i++) send_byte(s[i]);
      pick = $urandom_range(0, 3);
      b = (pick == 0) ? LF : (pick == 1) ? CR : 8'($urandom_range(0, 255));
      send_byte(b);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side: random stall per item, long holds on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    hold_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_done < hold_asked) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done++;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("[utf8_sanitize_line_split_unit] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_asked = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);

    for (int ph = 0; ph < 4; ph++) begin
      tx_calm = ph[0];
      rx_calm = ph[1];
      // sender runs flat out while the receiver holds off
      if (ph[0]) hold_asked++;
      while (sent < corner_bytes.size() + (ph + 1) * PHASE_ITEMS) send_random_text();
    end
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("[utf8_sanitize_line_split_unit] OK");
    end else begin
      $display("[utf8_sanitize_line_split_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/u8sls_pkg.sv
design/u8sls_in_if.sv
design/u8sls_out_if.sv
design/u8sls_front.sv
design/u8sls_queue.sv
design/u8sls_back.sv
design/utf8_sanitize_line_split_unit.sv
sim/u8sls_stream_checker.sv
sim/tb_top.sv
